// ----- rtl/cam_pkg.sv -----
// Shared types and constants for the conference audio mixer.
// No dependencies; every other rtl file imports this package.

package cam_pkg;

    localparam int SUM_W    = 23;
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 6;
    localparam int POS_W    = 8;
    localparam int MIX_W    = 24;
    localparam int MASK_W   = 64;

    localparam logic signed [MIX_W-1:0] SAT_MAX = 24'sd32767;
    localparam logic signed [MIX_W-1:0] SAT_MIN = -24'sd32767;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_REQ  = 1'b1;

    typedef enum logic [1:0] {
        REG_CONF   = 2'd0,
        REG_ACTIVE = 2'd1,
        REG_OE     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              conf_on;
        logic [MASK_W-1:0] active_mask;
        logic [MASK_W-1:0] oe_mask;
    } t_cfg;

    typedef struct packed {
        logic                mode;
        logic [CH_W-1:0]     channel;
        logic [POS_W-1:0]    position;
        logic [SAMPLE_W-1:0] sample;
        logic                present;
        logic                first;
    } t_item;

    typedef struct packed {
        logic                we;
        logic                first;
        logic                add_en;
        logic [SAMPLE_W-1:0] contrib;
    } t_wr;

endpackage

// ----- rtl/cam_cfg.sv -----
// Configuration register file behind the APB-style port.
// Depends on cam_pkg.

module cam_cfg
    import cam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic              r_conf;
    logic [MASK_W-1:0] r_active;
    logic [MASK_W-1:0] r_oe;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf   <= 1'b0;
            r_active <= '1;
            r_oe     <= '1;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_CONF:   r_conf   <= pwdata[0];
                REG_ACTIVE: r_active <= pwdata;
                REG_OE:     r_oe     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_CONF:   prdata = {63'd0, r_conf};
            REG_ACTIVE: prdata = r_active;
            REG_OE:     prdata = r_oe;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{conf_on: r_conf, active_mask: r_active, oe_mask: r_oe};

endmodule

// ----- rtl/cam_store.sv -----
// Sum and contribution memories with read-modify-write and write forwarding.
// Depends on cam_pkg.

module cam_store
    import cam_pkg::*;
#(
    parameter int CHANNELS      = 64,
    parameter int FRAME_SAMPLES = 256,
    localparam int PW = $clog2(FRAME_SAMPLES),
    localparam int IW = $clog2(CHANNELS * FRAME_SAMPLES)
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [PW-1:0]       i_rd_pos,
    input  logic [IW-1:0]       i_rd_idx,
    input  t_wr                 i_wr,
    output logic [SUM_W-1:0]    o_sum,
    output logic [SAMPLE_W-1:0] o_contrib
);

    logic [SUM_W-1:0]    r_sum_mem [FRAME_SAMPLES];
    logic [SAMPLE_W-1:0] r_con_mem [CHANNELS * FRAME_SAMPLES];

    logic [SUM_W-1:0]    r_sum_rd;
    logic [SAMPLE_W-1:0] r_con_rd;
    logic [PW-1:0]       r_wr_pos;
    logic [IW-1:0]       r_wr_idx;
    logic                r_sum_hit;
    logic                r_con_hit;
    logic [SUM_W-1:0]    r_sum_fwd;
    logic [SAMPLE_W-1:0] r_con_fwd;

    logic [SUM_W-1:0]    w_sum_base;
    logic [SUM_W-1:0]    w_sum_add;
    logic [SUM_W-1:0]    w_sum_new;

    assign o_sum     = r_sum_hit ? r_sum_fwd : r_sum_rd;
    assign o_contrib = r_con_hit ? r_con_fwd : r_con_rd;

    assign w_sum_base = i_wr.first ? '0 : o_sum;
    assign w_sum_add  = i_wr.add_en ? {{(SUM_W-SAMPLE_W){i_wr.contrib[SAMPLE_W-1]}}, i_wr.contrib}
                                    : '0;
    assign w_sum_new  = w_sum_base + w_sum_add;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_sum_mem[r_wr_pos] <= w_sum_new;
            r_con_mem[r_wr_idx] <= i_wr.contrib;
        end
    end

    // the read sees the old entry when the same entry is written at this edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sum_rd  <= r_sum_mem[i_rd_pos];
            r_con_rd  <= r_con_mem[i_rd_idx];
            r_wr_pos  <= i_rd_pos;
            r_wr_idx  <= i_rd_idx;
            r_sum_hit <= i_wr.we && (i_rd_pos == r_wr_pos);
            r_con_hit <= i_wr.we && (i_rd_idx == r_wr_idx);
            r_sum_fwd <= w_sum_new;
            r_con_fwd <= i_wr.contrib;
        end
    end

endmodule

// ----- rtl/cam_mix.sv -----
// Mix arithmetic, own-contribution removal, clamp and the output register.
// Depends on cam_pkg.

module cam_mix
    import cam_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_item               i_item,
    input  logic [SUM_W-1:0]    i_sum,
    input  logic [SAMPLE_W-1:0] i_contrib,
    input  logic                i_sub_own,
    input  logic                i_tready,
    output logic                o_free,
    output logic                o_tvalid,
    output logic [31:0]         o_tdata
);

    logic                       r_valid;
    logic [SAMPLE_W-1:0]        r_mixed;
    logic [CH_W-1:0]            r_ch;
    logic [POS_W-1:0]           r_pos;

    logic signed [MIX_W-1:0]    w_sum_x;
    logic signed [MIX_W-1:0]    w_own_x;
    logic signed [MIX_W-1:0]    w_mix;
    logic [SAMPLE_W-1:0]        w_clamped;

    assign w_sum_x = {i_sum[SUM_W-1], i_sum};
    assign w_own_x = i_sub_own ? {{(MIX_W-SAMPLE_W){i_contrib[SAMPLE_W-1]}}, i_contrib} : '0;
    assign w_mix   = w_sum_x - w_own_x;

    always_comb begin
        priority if (w_mix > SAT_MAX) begin
            w_clamped = SAT_MAX[SAMPLE_W-1:0];
        end else if (w_mix < SAT_MIN) begin
            w_clamped = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            w_clamped = w_mix[SAMPLE_W-1:0];
        end
    end

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_mixed <= w_clamped;
            r_ch    <= i_item.channel;
            r_pos   <= i_item.position;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {2'b00, r_pos, r_ch, r_mixed};

endmodule

// ----- rtl/conference_audio_mixer_unit.sv -----
// Conference audio mixer: one word accepted per cycle unless a request waits in stage 1.
// A word reads its memory entries at the accept edge; in stage 1 a request is mixed into
// the output register and a load writes back the sum and contribution memories, with
// forwarding to a following word on the same entry. Requests wait only on a full,
// stalled output register. Reset (synchronous, active low) clears control state and
// restores the register defaults; memory is not cleared and is undefined until written.

module conference_audio_mixer_unit
    import cam_pkg::*;
#(
    parameter int CHANNELS      = 64,
    parameter int FRAME_SAMPLES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // channel[5:0], position[13:6], sample[29:14],
                                       // present[30], first[31]
    input  logic        s_axis_tuser,  // mode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // mixed_sample[15:0], out_channel[21:16],
                                       // out_position[29:22], zero[31:30]
);

    localparam int PW = $clog2(FRAME_SAMPLES);
    localparam int IW = $clog2(CHANNELS * FRAME_SAMPLES);

    t_cfg                w_cfg;
    t_item               w_in;
    t_item               r_s1;
    logic                r_s1_valid;
    logic                w_accept;
    logic                w_in_range;
    logic                w_keep;
    logic                w_out_free;
    logic                w_s1_done;
    logic [PW-1:0]       w_rd_pos;
    logic [IW-1:0]       w_rd_idx;
    logic [31:0]         w_idx_full;
    t_wr                 w_wr;
    logic [SUM_W-1:0]    w_sum;
    logic [SAMPLE_W-1:0] w_contrib;
    logic                w_s1_active;

    cam_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_in = '{
        mode:     s_axis_tuser,
        channel:  s_axis_tdata[5:0],
        position: s_axis_tdata[13:6],
        sample:   s_axis_tdata[29:14],
        present:  s_axis_tdata[30],
        first:    s_axis_tdata[31]
    };

    assign w_in_range = (32'(w_in.channel) < 32'(CHANNELS))
                     && (32'(w_in.position) < 32'(FRAME_SAMPLES));
    // drop out-of-range words and requests for disabled outputs at the door
    assign w_keep     = w_in_range
                     && ((w_in.mode == MODE_LOAD) || w_cfg.oe_mask[w_in.channel]);

    assign w_idx_full = 32'(w_in.channel) * 32'(FRAME_SAMPLES) + 32'(w_in.position);
    assign w_rd_idx   = w_idx_full[IW-1:0];
    assign w_rd_pos   = PW'(w_in.position);

    assign w_s1_done     = r_s1_valid && ((r_s1.mode == MODE_LOAD) || w_out_free);
    assign s_axis_tready = !r_s1_valid || w_s1_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_keep;
        end else if (w_s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_in;
        end
    end

    assign w_s1_active = w_cfg.active_mask[r_s1.channel];

    assign w_wr = '{
        we:      r_s1_valid && (r_s1.mode == MODE_LOAD),
        first:   r_s1.first,
        add_en:  r_s1.present && w_s1_active,
        contrib: r_s1.present ? r_s1.sample : '0
    };

    cam_store #(
        .CHANNELS      (CHANNELS),
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept && w_keep),
        .i_rd_pos  (w_rd_pos),
        .i_rd_idx  (w_rd_idx),
        .i_wr      (w_wr),
        .o_sum     (w_sum),
        .o_contrib (w_contrib)
    );

    cam_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_s1_valid && (r_s1.mode == MODE_REQ)),
        .i_item    (r_s1),
        .i_sum     (w_sum),
        .i_contrib (w_contrib),
        .i_sub_own (w_cfg.conf_on && w_s1_active),
        .i_tready  (m_axis_tready),
        .o_free    (w_out_free),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata)
    );

endmodule

// ----- bench/conference_audio_mixer_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for conference_audio_mixer_unit: a directed table, then random frame
// bursts under several register settings, each result checked against a behavioral mixer.
// Depends on cam_pkg and rtl/conference_audio_mixer_unit.sv.

module conference_audio_mixer_unit_tb
    import cam_pkg::*;
();

    localparam int NCH           = 64;
    localparam int NPOS          = 256;
    localparam int MAX_GAP       = 14;
    localparam int WRAP_LOADS    = 135;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [4:0] ADDR_CONF   = {REG_CONF, 3'b000};
    localparam logic [4:0] ADDR_ACTIVE = {REG_ACTIVE, 3'b000};
    localparam logic [4:0] ADDR_OE     = {REG_OE, 3'b000};
    localparam logic [4:0] ADDR_SPARE  = 5'd24;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} t_chk_kind;

    typedef struct packed {
        logic signed [15:0] mix;
        logic [5:0]         ch;
        logic [7:0]         pos;
    } t_mix_word;

    typedef struct packed {
        t_row_kind          kind;
        logic               conf;
        logic [63:0]        act;
        logic [63:0]        oe;
        t_item              word;
        t_chk_kind          chk;
        logic signed [15:0] mix;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;  // channel[5:0], position[13:6], sample[29:14],
                                // present[30], first[31]
    logic        s_axis_tuser;  // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // mixed_sample[15:0], out_channel[21:16],
                                // out_position[29:22], zero[31:30]

    // mixer image kept by the bench
    logic              conf_q;
    logic [63:0]       active_q;
    logic [63:0]       oe_q;
    logic [SUM_W-1:0]  sum_mem [NPOS];
    logic [15:0]       contrib_mem [NCH][NPOS];
    bit                sum_seen [NPOS];
    bit                contrib_seen [NCH][NPOS];

    t_mix_word mix_due [$];
    t_plan_row plan [$];
    int        fail_count;
    int        words_sent;
    bit        calm;

    conference_audio_mixer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // Advance the mixer image by one accepted word; returns 1 when a mix comes out.
    function automatic bit mix_step(input t_item it, output t_mix_word res);
        logic [15:0]        contrib;
        logic signed [23:0] acc;
        logic               act;
        act = active_q[it.channel];
        res = '0;
        if (it.mode == MODE_LOAD) begin
            contrib = it.present ? it.sample : 16'h0000;
            if (it.first) begin
                sum_mem[it.position] = '0;
                sum_seen[it.position] = 1'b1;
            end
            contrib_mem[it.channel][it.position] = contrib;
            contrib_seen[it.channel][it.position] = 1'b1;
            if (it.present && act)
                sum_mem[it.position] = sum_mem[it.position]
                    + {{(SUM_W-16){contrib[15]}}, contrib};
            return 1'b0;
        end
        if (!oe_q[it.channel]) return 1'b0;
        acc = {sum_mem[it.position][SUM_W-1], sum_mem[it.position]};
        if (conf_q && act) begin
            contrib = contrib_mem[it.channel][it.position];
            acc = acc - {{8{contrib[15]}}, contrib};
        end
        if (acc > SAT_MAX) acc = SAT_MAX;
        else if (acc < SAT_MIN) acc = SAT_MIN;
        res.mix = acc[15:0];
        res.ch  = it.channel;
        res.pos = it.position;
        return 1'b1;
    endfunction

    // Keep away from entries that were never written: turn such a request into a load,
    // and start an unwritten sum with the first flag.
    function automatic t_item make_safe(input t_item it);
        t_item w;
        w = it;
        if (w.mode == MODE_REQ && (!sum_seen[w.position] ||
                (conf_q && active_q[w.channel] && !contrib_seen[w.channel][w.position])))
            w.mode = MODE_LOAD;
        if (w.mode == MODE_LOAD && !sum_seen[w.position]) w.first = 1'b1;
        return w;
    endfunction

    function automatic logic [15:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        if (r == 2) return 16'($urandom_range(0, 64)) - 16'd32;
        return 16'($urandom);
    endfunction

    function automatic t_item noise_word();
        t_item it;
        it.mode     = ($urandom_range(0, 1) == 1) ? MODE_REQ : MODE_LOAD;
        it.channel  = 6'($urandom);
        it.position = 8'($urandom);
        it.sample   = pick_sample();
        it.present  = 1'($urandom);
        it.first    = 1'($urandom);
        return it;
    endfunction

    task automatic send_word(input t_item it, input t_chk_kind chk,
                             input logic signed [15:0] fixed_mix);
        int unsigned gap;
        t_mix_word   res;
        bit          has;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {it.first, it.present, it.sample, it.position, it.channel};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        has = mix_step(it, res);
        if (chk == CHK_VALUE) begin
            has = 1'b1;
            res.mix = fixed_mix;
            res.ch  = it.channel;
            res.pos = it.position;
        end else if (chk == CHK_NONE) begin
            has = 1'b0;
        end
        if (has) mix_due.push_back(res);
        words_sent++;
    endtask

    // Drop valid, wait for every outstanding mix, then let the pipeline go quiet.
    task automatic settle();
        int n;
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (mix_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves psel high so that back-to-back transfers need no idle cycle.
    task automatic apb_write(input logic [4:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic conf, input logic [63:0] act, input logic [63:0] oe);
        apb_write(ADDR_CONF, {63'd0, conf});
        apb_write(ADDR_ACTIVE, act);
        apb_write(ADDR_OE, oe);
        // unmapped register: must change nothing
        apb_write(ADDR_SPARE, {$urandom, $urandom});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        conf_q   = conf;
        active_q = act;
        oe_q     = oe;
    endtask

    task automatic check_result(input logic [31:0] data);
        t_mix_word want;
        if (mix_due.size() == 0) begin
            flag_error($sformatf("result word %h with nothing outstanding", data));
            return;
        end
        want = mix_due.pop_front();
        if (data[15:0] !== want.mix || data[21:16] !== want.ch ||
                data[29:22] !== want.pos || data[31:30] !== 2'b00)
            flag_error($sformatf("mix ch %0d pos %0d: expected %0d, got %0d ch %0d pos %0d pad %b",
                want.ch, want.pos, want.mix, $signed(data[15:0]), data[21:16], data[29:22],
                data[31:30]));
    endtask

    task automatic plan_word(input logic mode, input logic [5:0] ch, input logic [7:0] pos,
                             input logic [15:0] smp, input logic pr, input logic fst,
                             input t_chk_kind chk, input logic signed [15:0] mix);
        t_plan_row row;
        row = '0;
        row.kind          = ROW_WORD;
        row.word.mode     = mode;
        row.word.channel  = ch;
        row.word.position = pos;
        row.word.sample   = smp;
        row.word.present  = pr;
        row.word.first    = fst;
        row.chk           = chk;
        row.mix           = mix;
        plan.push_back(row);
    endtask

    task automatic plan_cfg(input logic conf, input logic [63:0] act, input logic [63:0] oe);
        t_plan_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.conf = conf;
        row.act  = act;
        row.oe   = oe;
        plan.push_back(row);
    endtask

    task automatic build_plan();
        // reset setting: plain sum of every active channel
        plan_word(MODE_LOAD, 6'd0,  8'd0,   16'h7FFF, 1'b1, 1'b1, CHK_MODEL, 16'sd0);
        plan_word(MODE_LOAD, 6'd63, 8'd0,   16'h7FFF, 1'b1, 1'b0, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd0,  8'd0,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd32767);
        plan_word(MODE_LOAD, 6'd5,  8'd255, 16'h8000, 1'b1, 1'b1, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd63, 8'd255, 16'hFFFF, 1'b1, 1'b1, CHK_VALUE, -16'sd32767);
        // absent channel still clears with first
        plan_word(MODE_LOAD, 6'd1,  8'd1,   16'h1234, 1'b0, 1'b1, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd1,  8'd1,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd0);
        plan_word(MODE_LOAD, 6'd2,  8'd2,   16'hFF9C, 1'b1, 1'b1, CHK_MODEL, 16'sd0);
        plan_word(MODE_LOAD, 6'd3,  8'd2,   16'd300,  1'b1, 1'b0, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd2,  8'd2,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd200);
        // conference mode, channel 3 inactive, channel 4 output disabled
        plan_cfg(1'b1, ~64'h8, ~64'h10);
        plan_word(MODE_REQ,  6'd2,  8'd2,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd300);
        plan_word(MODE_REQ,  6'd4,  8'd2,   16'h0000, 1'b0, 1'b0, CHK_NONE,  16'sd0);
        plan_word(MODE_LOAD, 6'd3,  8'd2,   16'd500,  1'b1, 1'b0, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd3,  8'd2,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd200);
        plan_word(MODE_LOAD, 6'd3,  8'd4,   16'd777,  1'b1, 1'b1, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd3,  8'd4,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd0);
        // own contribution removal pushes past the lower clamp limit and up to the upper one
        plan_word(MODE_LOAD, 6'd63, 8'd255, 16'h7FFF, 1'b1, 1'b0, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd63, 8'd255, 16'h0000, 1'b0, 1'b0, CHK_VALUE, -16'sd32767);
        plan_word(MODE_REQ,  6'd5,  8'd255, 16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd32767);
        plan_word(MODE_LOAD, 6'd0,  8'd0,   16'h5A5A, 1'b0, 1'b0, CHK_MODEL, 16'sd0);
        plan_word(MODE_REQ,  6'd0,  8'd0,   16'h0000, 1'b0, 1'b0, CHK_VALUE, 16'sd32767);
    endtask

    // Loads into one position, mostly opening with first, then requests for that position.
    task automatic frame_burst();
        t_item      it;
        logic [5:0] loaded [$];
        logic [7:0] pos;
        int         n;
        pos = 8'($urandom);
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            it.mode     = MODE_LOAD;
            it.channel  = 6'($urandom);
            it.position = pos;
            it.sample   = pick_sample();
            it.present  = ($urandom_range(0, 9) != 0);
            it.first    = (k == 0) && ($urandom_range(0, 3) != 0);
            loaded.push_back(it.channel);
            send_word(make_safe(it), CHK_MODEL, 16'sd0);
        end
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            it = noise_word();
            it.mode     = MODE_REQ;
            it.position = pos;
            if ($urandom_range(0, 3) != 0)
                it.channel = loaded[$urandom_range(0, loaded.size() - 1)];
            send_word(make_safe(it), CHK_MODEL, 16'sd0);
        end
    endtask

    // Drive the 23-bit sum past its range at one position.
    task automatic wrap_run(input logic [15:0] smp);
        t_item it;
        it = '0;
        it.mode     = MODE_LOAD;
        it.position = 8'($urandom);
        it.sample   = smp;
        it.present  = 1'b1;
        for (int k = 0; k < WRAP_LOADS; k++) begin
            it.channel = 6'($urandom);
            it.first   = (k == 0);
            send_word(make_safe(it), CHK_MODEL, 16'sd0);
        end
        it.mode  = MODE_REQ;
        it.first = 1'b0;
        repeat (3) begin
            it.channel = 6'($urandom);
            send_word(make_safe(it), CHK_MODEL, 16'sd0);
        end
    endtask

    task automatic run_phase(input logic conf, input logic [63:0] act, input logic [63:0] oe,
                             input int words);
        int stop;
        settle();
        write_cfg(conf, act, oe);
        stop = words_sent + words;
        while (words_sent < stop) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) begin
                frame_burst();
            end else begin
                repeat ($urandom_range(1, 4)) send_word(make_safe(noise_word()), CHK_MODEL,
                                                        16'sd0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            check_result(m_axis_tdata);
        end
    end

    initial begin : stimulus
        t_plan_row row;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_LOAD;
        conf_q        = 1'b0;
        active_q      = '1;
        oe_q          = '1;
        fail_count    = 0;
        words_sent    = 0;
        calm          = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_plan();
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_cfg(row.conf, row.act, row.oe);
            end else begin
                send_word(row.word, row.chk, row.mix);
            end
        end

        run_phase(1'b0, '1, '1, 120);
        wrap_run(16'h7FFF);
        wrap_run(16'h8000);
        run_phase(1'b1, '1, {$urandom, $urandom}, 180);
        run_phase(1'b1, {$urandom, $urandom}, '1, 180);
        run_phase(1'b0, '0, {$urandom, $urandom}, 140);
        run_phase(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 180);
        run_phase(1'b1, '1, '0, 50);

        settle();
        if (mix_due.size() != 0)
            flag_error($sformatf("%0d mixes never arrived", mix_due.size()));
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
